/* rtl/core/iplc_pkg.sv */
// Shared types, format codes and status codes for the image plane layout checker.
package iplc_pkg;

    localparam int FMT_W     = 4;
    localparam int DIM_W     = 16;
    localparam int SIZE_W    = 40;
    localparam int PLANES_W  = 4;
    localparam int STRIDE_W  = 32;
    localparam int OFFSET_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int RBYTES_W  = DIM_W + 2;
    localparam int PROD_W    = STRIDE_W + DIM_W;
    localparam int END_W     = PROD_W + 1;
    localparam int IN_DATA_W = 208;
    localparam int OUT_DATA_W = 8;

    localparam logic [FMT_W-1:0] FMT_NV12     = 4'd1;
    localparam logic [FMT_W-1:0] FMT_NV16     = 4'd2;
    localparam logic [FMT_W-1:0] FMT_YUYV     = 4'd3;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 4'd4;
    localparam logic [FMT_W-1:0] FMT_RGB888   = 4'd5;
    localparam logic [FMT_W-1:0] FMT_ARGB8888 = 4'd6;
    localparam logic [FMT_W-1:0] FMT_BGRA8888 = 4'd7;

    localparam logic [PLANES_W-1:0] MAX_PLANES = 4'd4;
    localparam logic [PLANES_W-1:0] ONE_PLANE  = 4'd1;
    localparam logic [PLANES_W-1:0] TWO_PLANES = 4'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BADARGS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LAYOUT  = 2'd2;

    // Work handed to one plane lane.
    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [STRIDE_W-1:0] stride;
        logic [OFFSET_W-1:0] offset;
        logic [RBYTES_W-1:0] rbytes;
        logic [DIM_W-1:0]    rows;
    } lane_cmd_t;

    // What one lane found about its plane.
    typedef struct packed {
        logic                bad;
        logic [END_W-1:0]    alloc_end;
        logic [OFFSET_W-1:0] offset;
    } lane_res_t;

    // Descriptor-level verdict that travels beside the lanes.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                need2;
    } ctl_t;

endpackage

/* rtl/core/iplc_decode.sv */
// Argument and format checks, and per-plane row bytes and row counts.
module iplc_decode
(
    input  logic                              clk,
    input  logic                              load,
    input  logic [iplc_pkg::IN_DATA_W-1:0]    word,
    output iplc_pkg::ctl_t                    ctl,
    output iplc_pkg::lane_cmd_t               cmd0,
    output iplc_pkg::lane_cmd_t               cmd1
);

    logic [iplc_pkg::FMT_W-1:0]      fmt;
    logic [iplc_pkg::DIM_W-1:0]      w;
    logic [iplc_pkg::DIM_W-1:0]      h;
    logic [iplc_pkg::SIZE_W-1:0]     size;
    logic [iplc_pkg::PLANES_W-1:0]   planes;
    logic [iplc_pkg::STRIDE_W-1:0]   stride0;
    logic [iplc_pkg::OFFSET_W-1:0]   offset0;
    logic [iplc_pkg::STRIDE_W-1:0]   stride1;
    logic [iplc_pkg::OFFSET_W-1:0]   offset1;

    logic                            bad_args;
    logic                            fmt_bad;
    logic                            odd_dim;
    logic                            need2;
    logic [iplc_pkg::RBYTES_W-1:0]   rb0;
    logic [iplc_pkg::RBYTES_W-1:0]   rb1;
    logic [iplc_pkg::DIM_W-1:0]      rows1;

    iplc_pkg::ctl_t                  ctl_next;
    iplc_pkg::ctl_t                  ctl_reg;
    iplc_pkg::lane_cmd_t             cmd0_reg;
    iplc_pkg::lane_cmd_t             cmd1_reg;

    assign fmt     = word[3:0];
    assign w       = word[19:4];
    assign h       = word[35:20];
    assign size    = word[75:36];
    assign planes  = word[79:76];
    assign stride0 = word[111:80];
    assign offset0 = word[143:112];
    assign stride1 = word[175:144];
    assign offset1 = word[207:176];

    assign bad_args = (planes == '0) || (planes > iplc_pkg::MAX_PLANES) ||
                      (size == '0) || (w == '0) || (h == '0);

    always_comb
    begin
        fmt_bad = 1'b0;
        odd_dim = 1'b0;
        need2   = 1'b0;
        rb0     = {2'b00, w};
        rb1     = {2'b00, w};
        rows1   = h;
        case (fmt)
            iplc_pkg::FMT_NV12:
            begin
                odd_dim = w[0] | h[0];
                need2   = 1'b1;
                rows1   = {1'b0, h[iplc_pkg::DIM_W-1:1]};
            end
            iplc_pkg::FMT_NV16:
            begin
                odd_dim = w[0];
                need2   = 1'b1;
            end
            iplc_pkg::FMT_YUYV:
            begin
                odd_dim = w[0];
                rb0     = {1'b0, w, 1'b0};
            end
            iplc_pkg::FMT_RGB565:
            begin
                rb0 = {1'b0, w, 1'b0};
            end
            iplc_pkg::FMT_RGB888:
            begin
                rb0 = {2'b00, w} + {1'b0, w, 1'b0};
            end
            iplc_pkg::FMT_ARGB8888, iplc_pkg::FMT_BGRA8888:
            begin
                rb0 = {w, 2'b00};
            end
            default:
            begin
                fmt_bad = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ctl_next.need2 = need2;
        if (bad_args)
        begin
            ctl_next.status = iplc_pkg::STATUS_BADARGS;
        end
        else if (fmt_bad || odd_dim ||
                 (planes != (need2 ? iplc_pkg::TWO_PLANES : iplc_pkg::ONE_PLANE)))
        begin
            ctl_next.status = iplc_pkg::STATUS_LAYOUT;
        end
        else
        begin
            ctl_next.status = iplc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg         <= ctl_next;
            cmd0_reg.size   <= size;
            cmd0_reg.stride <= stride0;
            cmd0_reg.offset <= offset0;
            cmd0_reg.rbytes <= rb0;
            cmd0_reg.rows   <= h;
            cmd1_reg.size   <= size;
            cmd1_reg.stride <= stride1;
            cmd1_reg.offset <= offset1;
            cmd1_reg.rbytes <= rb1;
            cmd1_reg.rows   <= rows1;
        end
    end

    assign ctl  = ctl_reg;
    assign cmd0 = cmd0_reg;
    assign cmd1 = cmd1_reg;

endmodule

/* rtl/core/iplc_lane.sv */
// One plane lane: allocation extent and bounds checks over two pipeline stages.
module iplc_lane
(
    input  logic                  clk,
    input  logic                  advance,
    input  iplc_pkg::lane_cmd_t   cmd,
    output iplc_pkg::lane_res_t   res
);

    logic [iplc_pkg::PROD_W-1:0]   prod_reg;
    logic [iplc_pkg::OFFSET_W-1:0] offset_reg;
    logic [iplc_pkg::SIZE_W-1:0]   size_reg;
    logic                          early_bad_reg;

    logic [iplc_pkg::END_W-1:0]    alloc_next;
    iplc_pkg::lane_res_t           res_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg      <= cmd.stride * cmd.rows;
            offset_reg    <= cmd.offset;
            size_reg      <= cmd.size;
            early_bad_reg <= ({14'd0, cmd.rbytes} > cmd.stride) ||
                             ({8'd0, cmd.offset} >= cmd.size);
        end
    end

    // With the stride at least the row bytes, the data end never passes the
    // allocation end, so checking the allocation end covers both.
    assign alloc_next = {{(iplc_pkg::END_W - iplc_pkg::OFFSET_W){1'b0}}, offset_reg} +
                        {1'b0, prod_reg};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.bad       <= early_bad_reg ||
                (alloc_next > {{(iplc_pkg::END_W - iplc_pkg::SIZE_W){1'b0}}, size_reg});
            res_reg.alloc_end <= alloc_next;
            res_reg.offset    <= offset_reg;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/iplc_merge.sv */
// Combines the descriptor verdict with lane 0 and, for two-plane formats, lane 1, and holds the result word.
module iplc_merge
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  iplc_pkg::ctl_t                      ctl,
    input  iplc_pkg::lane_res_t                 res0,
    input  iplc_pkg::lane_res_t                 res1,
    input  logic                                out_ready,
    output logic                                advance,
    output logic                                out_valid,
    output logic [iplc_pkg::STATUS_W-1:0]       status
);

    logic                            out_valid_reg;
    logic [iplc_pkg::STATUS_W-1:0]   status_reg;
    logic [iplc_pkg::STATUS_W-1:0]   status_next;
    logic                            overlap;

    assign advance = !out_valid_reg || out_ready;

    assign overlap = {{(iplc_pkg::END_W - iplc_pkg::OFFSET_W){1'b0}}, res1.offset} <
                     res0.alloc_end;

    always_comb
    begin
        if (ctl.status != iplc_pkg::STATUS_OK)
        begin
            status_next = ctl.status;
        end
        else if (res0.bad || (ctl.need2 && (res1.bad || overlap)))
        begin
            status_next = iplc_pkg::STATUS_LAYOUT;
        end
        else
        begin
            status_next = iplc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

/* rtl/core/image_plane_layout_checker_core.sv */
// Image plane layout checker: skid input, decode, two plane lanes, merge, output register.
// A status word passes the decode register, both lane stages and the merge register.
// One descriptor per cycle is sustained while the output is not stalled.
// The input skid register keeps tready independent of the output side.
// Reset (rst_n low, asynchronous) empties the skid register and all stage valid bits.
// There is no kept state between descriptors.
module image_plane_layout_checker_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0 up: pixel_format, image_width, image_height, buffer_bytes,
    // planes_given, first_stride, first_offset, second_stride, second_offset.
    input  logic [iplc_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0 up: check_status, then zero fill.
    output logic [iplc_pkg::OUT_DATA_W-1:0]      m_tdata
);

    logic                              skid_valid_reg;
    logic [iplc_pkg::IN_DATA_W-1:0]    skid_data_reg;
    logic                              advance;
    logic                              s_accept;
    logic [iplc_pkg::IN_DATA_W-1:0]    stage_word;

    logic                              v1_reg;
    logic                              v2_reg;
    logic                              v3_reg;
    iplc_pkg::ctl_t                    ctl1;
    iplc_pkg::ctl_t                    ctl2_reg;
    iplc_pkg::ctl_t                    ctl3_reg;
    iplc_pkg::lane_cmd_t               cmd0;
    iplc_pkg::lane_cmd_t               cmd1;
    iplc_pkg::lane_res_t               res0;
    iplc_pkg::lane_res_t               res1;
    logic [iplc_pkg::STATUS_W-1:0]     status;

    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign stage_word = skid_valid_reg ? skid_data_reg : s_tdata;

    // A word that arrives while the pipeline is stalled waits in the skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && !advance)
        begin
            skid_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= skid_valid_reg || s_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl2_reg <= ctl1;
            ctl3_reg <= ctl2_reg;
        end
    end

    iplc_decode u_decode
    (
        .clk  (clk),
        .load (advance),
        .word (stage_word),
        .ctl  (ctl1),
        .cmd0 (cmd0),
        .cmd1 (cmd1)
    );

    iplc_lane u_lane0
    (
        .clk     (clk),
        .advance (advance),
        .cmd     (cmd0),
        .res     (res0)
    );

    iplc_lane u_lane1
    (
        .clk     (clk),
        .advance (advance),
        .cmd     (cmd1),
        .res     (res1)
    );

    iplc_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .ctl       (ctl3_reg),
        .res0      (res0),
        .res1      (res1),
        .out_ready (m_tready),
        .advance   (advance),
        .out_valid (m_tvalid),
        .status    (status)
    );

    assign m_tdata = {{(iplc_pkg::OUT_DATA_W - iplc_pkg::STATUS_W){1'b0}}, status};

endmodule
